// ===== design/jsrc_pkg.sv =====
// Shared types and constants for the JTAG shift and readback check unit.
`default_nettype none
package jsrc_pkg;

  typedef struct packed {
    logic       tms_level;
    logic [2:0] bit_count;
    logic [7:0] data_byte;
    logic [7:0] tdo_levels;
  } in_item_t;

  typedef struct packed {
    logic [7:0] captured_byte;
    logic       readback_mismatch;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic finish;
  } jsrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_bit;
    logic out_free;
  } jsrc_status_t;

  localparam int unsigned BYTE_W = 8;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOW    = 2'd1;
  localparam logic [1:0] ST_HIGH   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

endpackage
`default_nettype wire

// ===== design/jsrc_ctrl.sv =====
// Sequencer for the TCK phases of one command and the result handoff.
`default_nettype none
module jsrc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire jsrc_pkg::jsrc_status_t status,
  output jsrc_pkg::jsrc_cmd_t        cmd
);
  import jsrc_pkg::*;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOW;
        end
      end
      ST_LOW: begin
        // TDI settles with TCK low
        state_next = ST_HIGH;
      end
      ST_HIGH: begin
        // TCK high: sample TDO
        cmd.shift  = 1'b1;
        state_next = status.last_bit ? ST_FINISH : ST_LOW;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == ST_IDLE && in_valid))
    else $error("load outside idle");

  a_finish_after_high: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HIGH && status.last_bit) |=> (state == ST_FINISH))
    else $error("last bit did not lead to finish");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.shift, cmd.finish}))
    else $error("more than one command at once");

endmodule
`default_nettype wire

// ===== design/jsrc_datapath.sv =====
// Capture shifter, bit counter, sent-byte history and result register.
`default_nettype none
module jsrc_datapath #(
  parameter int unsigned HISTORY_BYTES = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire jsrc_pkg::in_item_t   in_data,
  input  wire jsrc_pkg::jsrc_cmd_t  cmd,
  output jsrc_pkg::jsrc_status_t    status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output jsrc_pkg::out_item_t       out_data
);
  import jsrc_pkg::*;

  logic [BYTE_W-1:0] tdo_sr;
  logic [BYTE_W-1:0] captured;
  logic [BYTE_W-1:0] data_hold;
  logic [3:0]        bits_left;
  logic [BYTE_W-1:0] history [HISTORY_BYTES];
  logic [BYTE_W-1:0] oldest;

  assign oldest          = history[HISTORY_BYTES-1];
  assign status.last_bit = (bits_left == 4'd1);
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // align the first sample (bit count-1) to bit 7
      tdo_sr    <= in_data.tdo_levels << (3'd0 - in_data.bit_count);
      captured  <= '0;
      data_hold <= in_data.data_byte;
    end else if (cmd.shift) begin
      tdo_sr   <= {tdo_sr[BYTE_W-2:0], 1'b0};
      captured <= {captured[BYTE_W-2:0], tdo_sr[BYTE_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
    end else if (cmd.load) begin
      bits_left <= (in_data.bit_count == 3'd0) ? 4'd8 : {1'b0, in_data.bit_count};
    end else if (cmd.shift) begin
      bits_left <= bits_left - 4'd1;
    end
  end

  // advance the history once the comparison has used the oldest byte
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_BYTES; i++) begin
        history[i] <= '0;
      end
    end else if (cmd.finish) begin
      history[0] <= data_hold;
      for (int i = 1; i < HISTORY_BYTES; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.captured_byte     <= captured;
      out_data.readback_mismatch <= (captured != oldest);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result overwrites a stalled beat");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished beat not presented");

  a_shift_counted: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> (bits_left != 4'd0))
    else $error("shift with no bits left");

endmodule
`default_nettype wire

// ===== design/jtag_shift_readback_check_unit.sv =====
// Top level of the JTAG shift and readback check unit.
`default_nettype none
// Each command beat shifts 1 to 8 bits (a count of 0 means 8) with TMS held,
// two TCK phases per bit: TDI driven with TCK low, then TDO sampled with TCK
// high. The TCK phase sequencer accepts a command in idle, steps through
// the low and high phases once per bit, loads the result in its finish
// state and returns to idle before the next command is accepted; the input
// is stalled from acceptance until that return and also while a finished
// result waits on a stalled output. The captured byte holds the samples MSB
// first in its low count bits, and the mismatch flag compares it with the
// data byte sent HISTORY_BYTES commands earlier (zero bytes after reset). One
// result beat per command; the output register lets the next command run
// while a result waits to be taken.
module jtag_shift_readback_check_unit #(
  parameter int unsigned HISTORY_BYTES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jsrc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jsrc_pkg::out_item_t      out_data
);
  import jsrc_pkg::*;

  jsrc_cmd_t    cmd;
  jsrc_status_t status;

  jsrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  jsrc_datapath #(
    .HISTORY_BYTES (HISTORY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
